FILE: src/dtlfo_pkg.sv
package dtlfo_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LFO_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWING_LIMIT = 3'd4;

  // Operation codes of an input item.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_NOTE_ON = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic               lfo_enable;
    logic [15:0]        first_wait;
    logic [15:0]        period_wait;
    logic signed [15:0] step_size;
    logic signed [15:0] swing_limit;
  } cfg_t;

  // One input item held in the input register.
  typedef struct packed {
    logic [1:0]        operation;
    logic signed [7:0] base_detune;
  } item_t;

endpackage

FILE: src/dtlfo_in_if.sv
interface dtlfo_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [7:0] base_detune;

  modport source (output valid, output operation, output base_detune, input ready);
  modport sink (input valid, input operation, input base_detune, output ready);
endinterface

FILE: src/dtlfo_out_if.sv
interface dtlfo_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] detune_value;
  logic               value_changed;

  modport source (output valid, output detune_value, output value_changed, input ready);
  modport sink (input valid, input detune_value, input value_changed, output ready);
endinterface

FILE: src/dtlfo_cfg_regs.sv
module dtlfo_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtlfo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dtlfo_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output dtlfo_pkg::cfg_t                     cfg
);
  import dtlfo_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a register write; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LFO_ENABLE:  cfg_nxt.lfo_enable  = cfg_wdata[0];
        REG_FIRST_WAIT:  cfg_nxt.first_wait  = cfg_wdata;
        REG_PERIOD_WAIT: cfg_nxt.period_wait = cfg_wdata;
        REG_STEP_SIZE:   cfg_nxt.step_size   = $signed(cfg_wdata);
        REG_SWING_LIMIT: cfg_nxt.swing_limit = $signed(cfg_wdata);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/dtlfo_core.sv
module dtlfo_core (
  input  logic              clk,
  input  logic              rst_n,
  input  dtlfo_pkg::cfg_t   cfg,
  input  logic              item_valid,
  input  dtlfo_pkg::item_t  item,
  output logic              take,
  dtlfo_out_if.source       out_ch
);
  import dtlfo_pkg::*;

  // LFO state.
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic        rev_r, rev_nxt;
  logic [15:0] last_r, last_nxt;

  // Result register.
  logic        out_valid_r;
  logic [15:0] value_r, value_nxt;
  logic        changed_r, changed_nxt;

  logic [15:0] base_ext;
  logic [15:0] delta;
  logic [15:0] bound;
  logic [15:0] sum;
  logic        turn;
  logic [15:0] tick_offset;
  logic [15:0] tick_value;

  // An item moves into the result register when that register is free or drains now.
  assign take = item_valid && (!out_valid_r || out_ch.ready);

  // One triangle step: add in the current direction, clamp and turn at the bound.
  assign base_ext    = {{8{item.base_detune[7]}}, item.base_detune};
  assign delta       = rev_r ? 16'(16'd0 - cfg.step_size) : cfg.step_size;
  assign bound       = rev_r ? 16'(16'd0 - cfg.swing_limit) : cfg.swing_limit;
  assign sum         = 16'(offset_r + delta);
  assign turn        = delta[15] ? ($signed(sum) <= $signed(bound))
                                 : ($signed(sum) >= $signed(bound));
  assign tick_offset = (wait_r != 16'd0) ? offset_r : (turn ? bound : sum);
  assign tick_value  = 16'(base_ext + tick_offset);

  // Next state and result for the item in the input register.
  always_comb begin
    wait_nxt    = wait_r;
    offset_nxt  = offset_r;
    rev_nxt     = rev_r;
    last_nxt    = last_r;
    value_nxt   = last_r;
    changed_nxt = 1'b0;
    case (item.operation)
      OP_CLEAR: begin
        wait_nxt   = '0;
        offset_nxt = '0;
        rev_nxt    = 1'b0;
        last_nxt   = '0;
        value_nxt  = '0;
      end
      OP_NOTE_ON: begin
        last_nxt  = base_ext;
        value_nxt = base_ext;
        if (cfg.lfo_enable) begin
          wait_nxt   = cfg.first_wait;
          offset_nxt = '0;
          rev_nxt    = 1'b0;
        end
      end
      OP_TICK: begin
        if (cfg.lfo_enable) begin
          if (wait_r != 16'd0) begin
            wait_nxt = 16'(wait_r - 16'd1);
          end else begin
            wait_nxt   = cfg.period_wait;
            offset_nxt = tick_offset;
            rev_nxt    = rev_r ^ turn;
          end
          value_nxt = tick_value;
          if (tick_value != last_r) begin
            changed_nxt = 1'b1;
            last_nxt    = tick_value;
          end
        end
      end
      default: begin
        value_nxt = last_r;
      end
    endcase
  end

  // State updates only on a transfer into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r   <= '0;
      offset_r <= '0;
      rev_r    <= 1'b0;
      last_r   <= '0;
    end else if (take) begin
      wait_r   <= wait_nxt;
      offset_r <= offset_nxt;
      rev_r    <= rev_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value_r   <= value_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.detune_value  = $signed(value_r);
  assign out_ch.value_changed = changed_r;

`ifndef SYNTHESIS
  // Every shown result equals the last value that the state remembers.
  a_last_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (value_r == last_r))
    else $error("result differs from remembered last value");

  // A clear yields a zero result without a change flag.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.operation == OP_CLEAR) |=>
      (out_valid_r && value_r == 16'd0 && !changed_r && offset_r == 16'd0))
    else $error("clear did not give a zero result");

  // While the wait runs down, an enabled tick only decrements it.
  a_wait_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.operation == OP_TICK && cfg.lfo_enable && wait_r != 16'd0) |=>
      (wait_r == 16'($past(wait_r) - 16'd1) && $stable(offset_r) && $stable(rev_r)))
    else $error("wait countdown disturbed the offset");

  // With the LFO disabled only a clear can move the offset or direction.
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !cfg.lfo_enable && item.operation != OP_CLEAR) |=>
      ($stable(offset_r) && $stable(rev_r) && $stable(wait_r)))
    else $error("disabled LFO changed its state");
`endif

endmodule

FILE: src/detune_triangle_lfo_unit.sv
// Delayed triangle detune LFO for one channel. Each transfer on in_ch carries one
// operation (channel clear, note-on restart or one sequencer tick) with the channel's
// static detune, and produces exactly one result on out_ch: the detune plus the LFO
// offset, wrapping at 16 bits, and a flag that marks a tick whose value changed.
// The block takes one item every clock cycle while out_ch keeps draining. An item
// taken into the input register moves into the result register once that register is
// free or drains, and its result is then offered on out_ch. With out_ch
// stalled, the two registers hold two items before in_ch.ready drops. The clock rate
// is bounded by the path from the state through the offset add, the signed limit
// compare and clamp, the add of the base detune and the compare with the last value.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect on the next cycle
// and should be made while no item is in flight.
module detune_triangle_lfo_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  dtlfo_in_if.sink                          in_ch,
  dtlfo_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [dtlfo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtlfo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dtlfo_pkg::*;

  cfg_t  cfg;
  logic  s1_valid_r;
  item_t s1_item_r;
  logic  take;

  dtlfo_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register: refilled whenever it is empty or its item moves on.
  assign in_ch.ready = !s1_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.operation   <= in_ch.operation;
      s1_item_r.base_detune <= in_ch.base_detune;
    end
  end

  dtlfo_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule
